### rtl/bcrf_pkg.sv
// Shared constants and controller/datapath command and status types for the region fill block.
`default_nettype none

package bcrf_pkg;

  localparam int unsigned ROW_W    = 64;
  localparam int unsigned ROWNUM_W = 6;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

  // Register index codes, taken from paddr[2]
  localparam logic REG_COLS = 1'b0;

  typedef struct packed {
    logic load;
    logic flood_start;
    logic resweep;
    logic step;
    logic out_start;
    logic out_load;
    logic out_next;
    logic grid_done;
  } dp_cmd_t;

  typedef struct packed {
    logic last_row;
    logic changed;
    logic out_taken;
    logic out_last;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/bcrf_in_if.sv
// Input channel: one grid row per beat.
`default_nettype none

interface bcrf_in_if;
  import bcrf_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_cells;
  logic             final_row;

  modport source (output valid, output row_cells, output final_row, input ready);
  modport sink   (input valid, input row_cells, input final_row, output ready);
endinterface

`default_nettype wire

### rtl/bcrf_out_if.sv
// Output channel: one filled row per beat.
`default_nettype none

interface bcrf_out_if;
  import bcrf_pkg::*;

  logic                valid;
  logic                ready;
  logic [ROW_W-1:0]    filled_row;
  logic [ROWNUM_W-1:0] row_number;
  logic                last_of_grid;
  logic                rows_dropped;

  modport source (output valid, output filled_row, output row_number,
                  output last_of_grid, output rows_dropped, input ready);
  modport sink   (input valid, input filled_row, input row_number,
                  input last_of_grid, input rows_dropped, output ready);
endinterface

`default_nettype wire

### rtl/bcrf_ctrl.sv
// Sequencer for row loading, flood sweeps and result readout.
`default_nettype none

module bcrf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_final_i,
  output logic               in_ready_o,
  input  bcrf_pkg::dp_stat_t stat_i,
  output bcrf_pkg::dp_cmd_t  cmd_o
);
  import bcrf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRIME = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_ORD   = 3'd4;
  localparam logic [2:0] S_OLD   = 3'd5;
  localparam logic [2:0] S_OWAIT = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_final_i) begin
            cmd_o.flood_start = 1'b1;
            state_d           = S_PRIME;
          end
        end
      end
      S_PRIME: begin
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        cmd_o.step = 1'b1;
        if (stat_i.last_row) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        // repeat the sweep until a whole pass leaves the reach rows unchanged
        if (stat_i.changed) begin
          cmd_o.resweep = 1'b1;
          state_d       = S_PRIME;
        end else begin
          cmd_o.out_start = 1'b1;
          state_d         = S_ORD;
        end
      end
      S_ORD: begin
        state_d = S_OLD;
      end
      S_OLD: begin
        cmd_o.out_load = 1'b1;
        state_d        = S_OWAIT;
      end
      S_OWAIT: begin
        if (stat_i.out_taken) begin
          if (stat_i.out_last) begin
            cmd_o.grid_done = 1'b1;
            state_d         = S_IDLE;
          end else begin
            cmd_o.out_next = 1'b1;
            state_d        = S_ORD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_taken_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.out_taken |-> (state_q == S_OWAIT))
    else $error("output beat taken outside the wait state");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> $past(stat_i.out_taken && stat_i.out_last))
    else $error("returned to idle before the last row was delivered");

endmodule

`default_nettype wire

### rtl/bcrf_dp.sv
// Datapath: grid and reach memories, sweep window, row counters and output register.
`default_nettype none

module bcrf_dp #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bcrf_pkg::CFG_W-1:0]    cols_i,
  input  logic [bcrf_pkg::ROW_W-1:0]    in_cells_i,
  input  bcrf_pkg::dp_cmd_t             cmd_i,
  output bcrf_pkg::dp_stat_t            stat_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [bcrf_pkg::ROW_W-1:0]    out_row_o,
  output logic [bcrf_pkg::ROWNUM_W-1:0] out_num_o,
  output logic                          out_last_o,
  output logic                          out_drop_o
);
  import bcrf_pkg::*;

  localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned RW = $clog2(MAX_ROWS + 1);
  localparam logic [RW-1:0]    ROWS_MAX = RW'(MAX_ROWS);
  localparam logic [CFG_W-1:0] COLS_MAX = CFG_W'(MAX_COLS);
  localparam logic [MAX_COLS-1:0] ONE_C = MAX_COLS'(1);

  logic [MAX_COLS-1:0] grid_mem  [MAX_ROWS];
  logic [MAX_COLS-1:0] reach_mem [MAX_ROWS];

  logic [RW-1:0]       rows_loaded_q;
  logic                overflow_q;
  logic [AW-1:0]       ptr_q;
  logic                first_q;
  logic                changed_q;
  logic [MAX_COLS-1:0] prev_q;
  logic [MAX_COLS-1:0] rd_a_q, rd_b_q, rd_g_q;
  logic                out_valid_q;
  logic [ROW_W-1:0]    out_row_q;
  logic [ROWNUM_W-1:0] out_num_q;
  logic                out_last_q;
  logic                out_drop_q;

  logic                room;
  logic                last_row;
  logic [AW-1:0]       rd_base, rd_next;
  logic [MAX_COLS-1:0] col_mask, edges, cur, nxt, open_cells, seed, nr;

  assign room     = (rows_loaded_q < ROWS_MAX);
  assign last_row = ((RW'(ptr_q) + RW'(1)) == rows_loaded_q);
  // during a sweep, fetch one row ahead of the row being updated
  assign rd_base  = cmd_i.step ? (ptr_q + AW'(1)) : ptr_q;
  assign rd_next  = rd_base + AW'(1);

  assign col_mask = {MAX_COLS{1'b1}} >> (COLS_MAX - cols_i);
  assign edges    = ONE_C | (ONE_C << (cols_i - CFG_W'(1)));

  // first sweep: reach rows at and below the current one hold nothing yet
  assign cur        = first_q ? '0 : rd_a_q;
  assign nxt        = (first_q || last_row) ? '0 : rd_b_q;
  assign open_cells = rd_g_q & col_mask;
  assign seed       = ((ptr_q == '0) || last_row) ? col_mask : edges;
  assign nr         = (cur | (cur << 1) | (cur >> 1) | prev_q | nxt | seed) & open_cells;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      grid_mem[rows_loaded_q[AW-1:0]] <= in_cells_i[MAX_COLS-1:0];
    end
    rd_g_q <= grid_mem[rd_base];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      reach_mem[ptr_q] <= nr;
    end
    rd_a_q <= reach_mem[rd_base];
    rd_b_q <= reach_mem[rd_next];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_loaded_q <= '0;
      overflow_q    <= 1'b0;
      ptr_q         <= '0;
      first_q       <= 1'b0;
      changed_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (room) begin
          rows_loaded_q <= rows_loaded_q + RW'(1);
        end else begin
          overflow_q <= 1'b1;
        end
      end
      if (cmd_i.grid_done) begin
        rows_loaded_q <= '0;
        overflow_q    <= 1'b0;
      end
      if (cmd_i.flood_start || cmd_i.resweep || cmd_i.out_start) begin
        ptr_q <= '0;
      end else if (cmd_i.step || cmd_i.out_next) begin
        ptr_q <= ptr_q + AW'(1);
      end
      if (cmd_i.flood_start) begin
        first_q <= 1'b1;
      end else if (cmd_i.resweep) begin
        first_q <= 1'b0;
      end
      if (cmd_i.flood_start || cmd_i.resweep) begin
        changed_q <= 1'b0;
      end else if (cmd_i.step && (nr != cur)) begin
        changed_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.flood_start || cmd_i.resweep) begin
      prev_q <= '0;
    end else if (cmd_i.step) begin
      prev_q <= nr;
    end
    if (cmd_i.out_load) begin
      out_row_q  <= ROW_W'(rd_a_q & col_mask);
      out_num_q  <= ROWNUM_W'(ptr_q);
      out_last_q <= last_row;
      out_drop_q <= overflow_q;
    end
  end

  assign stat_o.last_row  = last_row;
  assign stat_o.changed   = changed_q;
  assign stat_o.out_taken = out_valid_q && out_ready_i;
  assign stat_o.out_last  = out_last_q;

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_num_o   = out_num_q;
  assign out_last_o  = out_last_q;
  assign out_drop_o  = out_drop_q;

  a_rows_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_loaded_q <= ROWS_MAX)
    else $error("row count beyond storage depth");

  a_step_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (RW'(ptr_q) < rows_loaded_q))
    else $error("sweep updates a row that was not loaded");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !out_valid_q)
    else $error("output register overwritten before its beat was taken");

endmodule

`default_nettype wire

### rtl/border_connected_region_fill_top.sv
// Border-connected region fill (4-connected hole fill): top level with APB register.
//
// Usage:
//   rows_i carries one grid row per beat (bit j = column j, 1 open, 0 wall);
//   final_row closes the grid. A non-final row is stored when taken. Rows
//   beyond MAX_ROWS are dropped and flagged on every result row of that grid.
//   After the final row the block floods from all open border cells and
//   turns every unreached open cell into wall. Each sweep passes over the m
//   stored rows, one row per cycle through the reach memory with one
//   read-ahead, and sweeps repeat until one leaves all rows unchanged; the
//   sweep count grows with the longest path of open cells.
//   fill_o then delivers m rows one at a time, each after the one before is
//   taken, the last row marked with last_of_grid. A stall holds the current
//   row in the output register; no new row is taken until the grid is out.
//   Register 0 (address 0) holds columns_in_use, reset 64; 0 acts as 1 and
//   values above MAX_COLS act as MAX_COLS. Write it only while idle.
//   Reset returns the block to idle with an empty grid; no clearing pass.
`default_nettype none

module border_connected_region_fill_top #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bcrf_in_if.sink                      rows_i,
  bcrf_out_if.source                   fill_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcrf_pkg::PADDR_W-1:0] paddr,
  input  logic [bcrf_pkg::PDATA_W-1:0] pwdata,
  output logic [bcrf_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import bcrf_pkg::*;

  localparam logic [CFG_W-1:0] COLS_MAX = CFG_W'(MAX_COLS);

  logic [CFG_W-1:0] cols_q;
  logic [CFG_W-1:0] cols_eff;
  logic             cfg_wr;
  logic             in_ready;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_COLS);
  assign prdata = (paddr[2] == REG_COLS) ? PDATA_W'(cols_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
    end else if (cfg_wr) begin
      cols_q <= pwdata[CFG_W-1:0];
    end
  end

  // clamp the column count into 1..MAX_COLS
  always_comb begin
    priority if (cols_q == '0) begin
      cols_eff = CFG_W'(1);
    end else if (cols_q > COLS_MAX) begin
      cols_eff = COLS_MAX;
    end else begin
      cols_eff = cols_q;
    end
  end

  assign rows_i.ready = in_ready;

  bcrf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rows_i.valid),
    .in_final_i (rows_i.final_row),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bcrf_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cols_i      (cols_eff),
    .in_cells_i  (rows_i.row_cells),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (fill_o.ready),
    .out_valid_o (fill_o.valid),
    .out_row_o   (fill_o.filled_row),
    .out_num_o   (fill_o.row_number),
    .out_last_o  (fill_o.last_of_grid),
    .out_drop_o  (fill_o.rows_dropped)
  );

endmodule

`default_nettype wire

### bench/border_connected_region_fill_top_test.sv
// Self-checking bench for the border-connected region fill block: directed and random grids.
module border_connected_region_fill_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bcrf_pkg::*;

  localparam int ROWS_MAX = 64;
  localparam int COLS_MAX = 64;
  localparam int PLAN_DEPTH = ROWS_MAX + 8;
  localparam int SETTLE_CYCLES = 10;
  localparam int TAIL_CYCLES = 50;
  localparam int RANDOM_ROWS = 280;
  localparam logic [PADDR_W-1:0] COLS_ADDR = {REG_COLS, 2'b00};

  typedef struct packed {
    logic [ROW_W-1:0]    filled_row;
    logic [ROWNUM_W-1:0] row_number;
    logic                last_of_grid;
    logic                rows_dropped;
  } fill_beat_t;

  typedef enum int {SHAPE_NOISE, SHAPE_BOXES, SHAPE_SNAKE} shape_e;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  bcrf_in_if  rows_if ();
  bcrf_out_if fill_if ();

  border_connected_region_fill_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rows_i  (rows_if),
    .fill_o  (fill_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the block state
  logic [ROW_W-1:0] grid_rows [ROWS_MAX];
  int               rows_held;
  logic             overflow_pending;
  logic [CFG_W-1:0] cols_reg;

  fill_beat_t       fill_expected [$];
  int               error_count;

  logic [ROW_W-1:0] plan_rows [PLAN_DEPTH];
  bit               pacing_on;
  int               burst_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("border_connected_region_fill_top verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic int eff_cols();
    int n;
    n = int'(cols_reg);
    if (n < 1) n = 1;
    if (n > COLS_MAX) n = COLS_MAX;
    return n;
  endfunction

  function automatic logic [ROW_W-1:0] col_mask(input int n);
    if (n >= ROW_W) return '1;
    return (ROW_W'(1) << n) - ROW_W'(1);
  endfunction

  // Store one accepted row; on the final row flood from the border and queue the grid
  task automatic absorb_row(input logic [ROW_W-1:0] cells, input logic last_row);
    logic [ROW_W-1:0] reach [ROWS_MAX];
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] edges;
    logic [ROW_W-1:0] open_cells;
    logic [ROW_W-1:0] nr;
    fill_beat_t       beat;
    bit               changed;
    int               m;
    int               n;
    int               i;
    if (rows_held < ROWS_MAX) begin
      grid_rows[rows_held] = cells;
      rows_held++;
    end else begin
      overflow_pending = 1'b1;
    end
    if (!last_row) return;
    m = rows_held;
    n = eff_cols();
    mask = col_mask(n);
    edges = ROW_W'(1) | (ROW_W'(1) << (n - 1));
    for (i = 0; i < m; i++) begin
      open_cells = grid_rows[i] & mask;
      reach[i] = (i == 0 || i == m - 1) ? open_cells : (open_cells & edges);
    end
    do begin
      changed = 1'b0;
      for (i = 0; i < m; i++) begin
        nr = reach[i] | (reach[i] << 1) | (reach[i] >> 1);
        if (i > 0) nr |= reach[i-1];
        if (i + 1 < m) nr |= reach[i+1];
        nr &= grid_rows[i] & mask;
        if (nr != reach[i]) begin
          reach[i] = nr;
          changed = 1'b1;
        end
      end
    end while (changed);
    for (i = 0; i < m; i++) begin
      beat.filled_row   = reach[i] & mask;
      beat.row_number   = ROWNUM_W'(i);
      beat.last_of_grid = (i == m - 1);
      beat.rows_dropped = overflow_pending;
      fill_expected.push_back(beat);
    end
    rows_held = 0;
    overflow_pending = 1'b0;
  endtask

  task automatic send_row(input logic [ROW_W-1:0] cells, input logic last_row);
    int gap;
    if (pacing_on) begin
      if (burst_left <= 0) begin
        gap = $urandom_range(1, 8);
        @(negedge clk_i);
        rows_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    @(negedge clk_i);
    rows_if.valid     = 1'b1;
    rows_if.row_cells = cells;
    rows_if.final_row = last_row;
    do @(posedge clk_i); while (!rows_if.ready);
    absorb_row(cells, last_row);
  endtask

  task automatic send_plan(input int m);
    int r;
    for (r = 0; r < m; r++) send_row(plan_rows[r], r == m - 1);
  endtask

  // Drop valid and hold until the block has delivered every queued beat
  task automatic wait_all_results();
    @(negedge clk_i);
    rows_if.valid = 1'b0;
    while (fill_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = addr;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_columns(input logic [CFG_W-1:0] want);
    logic [PDATA_W-1:0] back;
    apb_read(COLS_ADDR, back);
    if (back[CFG_W-1:0] !== want)
      report_mismatch($sformatf("columns_in_use read %0d, expected %0d",
                                back[CFG_W-1:0], want));
  endtask

  task automatic set_columns(input logic [CFG_W-1:0] value);
    wait_all_results();
    apb_write(COLS_ADDR, PDATA_W'(value));
    cols_reg = value;
    check_columns(value);
  endtask

  function automatic logic [ROW_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ROW_W-1:0] random_row();
    case ($urandom_range(0, 7))
      0: return rand_word() & rand_word();
      1: return rand_word() | rand_word();
      2: return rand_word() | rand_word() | rand_word();
      3: return '1;
      4: return '0;
      default: return rand_word();
    endcase
  endfunction

  task automatic plan_grid(input shape_e shape, input int m);
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] pat;
    int n;
    int r;
    int c;
    int h;
    int w;
    int r0;
    int c0;
    n = eff_cols();
    mask = col_mask(n);
    if (shape == SHAPE_SNAKE && (m < 3 || n < 4 || m > 16)) shape = SHAPE_NOISE;
    case (shape)
      SHAPE_SNAKE: begin
        // Single winding corridor entered at the top, walls on both sides
        for (r = 0; r < m; r++) begin
          if (r == 0) pat = ROW_W'(2);
          else if (r == m - 1) pat = '0;
          else if (r % 2 == 1) pat = mask & ~(ROW_W'(1) | (ROW_W'(1) << (n - 1)));
          else if ((r / 2) % 2 == 1) pat = ROW_W'(1) << (n - 2);
          else pat = ROW_W'(2);
          plan_rows[r] = (pat & mask) | (rand_word() & ~mask);
        end
        if ($urandom_range(0, 1) == 1) begin
          r = $urandom_range(1, m - 2);
          c = $urandom_range(1, n - 2);
          plan_rows[r][c] = 1'b0;
        end
      end
      SHAPE_BOXES: begin
        for (r = 0; r < m; r++) plan_rows[r] = rand_word() | rand_word() | rand_word();
        if (m >= 3 && n >= 3) begin
          repeat ($urandom_range(1, 3)) begin
            h = $urandom_range(3, (m < 8) ? m : 8);
            w = $urandom_range(3, (n < 10) ? n : 10);
            r0 = $urandom_range(0, m - h);
            c0 = $urandom_range(0, n - w);
            for (r = r0; r < r0 + h; r++) begin
              for (c = c0; c < c0 + w; c++) begin
                if (r == r0 || r == r0 + h - 1 || c == c0 || c == c0 + w - 1)
                  plan_rows[r][c] = 1'b0;
                else
                  plan_rows[r][c] = ($urandom_range(0, 3) != 0);
              end
            end
          end
        end
      end
      default: begin
        for (r = 0; r < m; r++) plan_rows[r] = random_row();
      end
    endcase
  endtask

  function automatic logic [CFG_W-1:0] pick_columns();
    case ($urandom_range(0, 7))
      0: return CFG_W'(0);
      1: return CFG_W'(1);
      2: return CFG_W'(2);
      3: return CFG_W'(COLS_MAX);
      4: return CFG_W'($urandom_range(COLS_MAX + 1, 127));
      default: return CFG_W'($urandom_range(3, COLS_MAX - 1));
    endcase
  endfunction

  task automatic test_register_access();
    check_columns(COLS_RESET);
    set_columns(CFG_W'(127));
    set_columns(CFG_W'(0));
    set_columns(CFG_W'(COLS_MAX));
  endtask

  task automatic test_directed_grids();
    pacing_on = 1'b1;
    // single row, every cell on the border
    plan_rows[0] = '1;
    send_plan(1);
    plan_rows[0] = '0;
    send_plan(1);
    // enclosed cell at column 1 is filled, border cell at column 63 stays
    plan_rows[0] = '0;
    plan_rows[1] = 64'h8000_0000_0000_0002;
    plan_rows[2] = '0;
    send_plan(3);
    // interior run reached through a top border opening
    plan_rows[0] = 64'h0000_0000_0000_0002;
    plan_rows[1] = 64'h7FFF_FFFF_FFFF_FFFE;
    plan_rows[2] = '0;
    send_plan(3);
    // checkerboard: interior cells have no open neighbor
    plan_rows[0] = 64'h5555_5555_5555_5555;
    plan_rows[1] = 64'hAAAA_AAAA_AAAA_AAAA;
    plan_rows[2] = 64'h5555_5555_5555_5555;
    plan_rows[3] = 64'hAAAA_AAAA_AAAA_AAAA;
    send_plan(4);
    // single column
    set_columns(CFG_W'(1));
    plan_rows[0] = '1;
    plan_rows[1] = 64'hFFFF_FFFF_FFFF_FFFE;
    send_plan(2);
    // zero columns acts as one
    set_columns(CFG_W'(0));
    plan_rows[0] = rand_word();
    send_plan(1);
    // above the maximum acts as the maximum
    set_columns(CFG_W'(127));
    plan_rows[0] = '0;
    plan_rows[1] = 64'h8000_0000_0000_0002;
    plan_rows[2] = '0;
    send_plan(3);
    // three columns, hole in the middle, bits above the columns set
    set_columns(CFG_W'(3));
    plan_rows[0] = 64'hFFFF_FFFF_FFFF_FFF8;
    plan_rows[1] = 64'hFFFF_FFFF_FFFF_FFFA;
    plan_rows[2] = 64'hFFFF_FFFF_FFFF_FFF8;
    send_plan(3);
    set_columns(CFG_W'(COLS_MAX));
  endtask

  task automatic test_random_grids();
    int     rows_sent;
    int     grids;
    int     m;
    int     pick;
    bit     full_done;
    bit     overflow_done;
    shape_e shape;
    rows_sent = 0;
    grids = 0;
    full_done = 1'b0;
    overflow_done = 1'b0;
    while (rows_sent < RANDOM_ROWS) begin
      if (grids % 10 == 0) begin
        set_columns(pick_columns());
        pacing_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (!full_done && rows_sent >= 60) begin
        m = ROWS_MAX;
        full_done = 1'b1;
      end else if (!overflow_done && rows_sent >= 140) begin
        m = $urandom_range(ROWS_MAX + 1, ROWS_MAX + 4);
        overflow_done = 1'b1;
      end else if (pick < 60) begin
        m = $urandom_range(1, 6);
      end else if (pick < 90) begin
        m = $urandom_range(7, 16);
      end else begin
        m = $urandom_range(17, 40);
      end
      shape = shape_e'($urandom_range(0, 2));
      plan_grid(shape, m);
      send_plan(m);
      rows_sent += m;
      grids++;
    end
  endtask

  // Receiver stall pattern: free-running, random, or long stalls
  initial begin : sink_ready
    int mode;
    int mode_left;
    int stall_left;
    mode = 0;
    mode_left = 0;
    stall_left = 0;
    fill_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left <= 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(40, 300);
      end
      mode_left--;
      case (mode)
        0: fill_if.ready = 1'b1;
        1: fill_if.ready = ($urandom_range(0, 2) != 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            fill_if.ready = 1'b0;
          end else if ($urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 15);
            fill_if.ready = 1'b0;
          end else begin
            fill_if.ready = 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin : check_fill
    fill_beat_t want;
    fill_beat_t got;
    if (rst_ni && fill_if.valid && fill_if.ready) begin
      got.filled_row   = fill_if.filled_row;
      got.row_number   = fill_if.row_number;
      got.last_of_grid = fill_if.last_of_grid;
      got.rows_dropped = fill_if.rows_dropped;
      if (fill_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected beat: row %h num %0d last %b dropped %b",
                                  got.filled_row, got.row_number, got.last_of_grid,
                                  got.rows_dropped));
      end else begin
        want = fill_expected.pop_front();
        if (got.filled_row !== want.filled_row)
          report_mismatch($sformatf("row %0d filled_row exp %h got %h",
                                    want.row_number, want.filled_row, got.filled_row));
        if (got.row_number !== want.row_number)
          report_mismatch($sformatf("row_number exp %0d got %0d",
                                    want.row_number, got.row_number));
        if (got.last_of_grid !== want.last_of_grid)
          report_mismatch($sformatf("row %0d last_of_grid exp %b got %b",
                                    want.row_number, want.last_of_grid, got.last_of_grid));
        if (got.rows_dropped !== want.rows_dropped)
          report_mismatch($sformatf("row %0d rows_dropped exp %b got %b",
                                    want.row_number, want.rows_dropped, got.rows_dropped));
      end
    end
  end

  initial begin : run
    rst_ni = 1'b0;
    rows_if.valid = 1'b0;
    rows_if.row_cells = '0;
    rows_if.final_row = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rows_held = 0;
    overflow_pending = 1'b0;
    cols_reg = COLS_RESET;
    error_count = 0;
    pacing_on = 1'b1;
    burst_left = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_access();
    test_directed_grids();
    test_random_grids();

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("border_connected_region_fill_top verification clean");
    end else begin
      $display("border_connected_region_fill_top verification failed");
    end
    $finish;
  end

endmodule

### border_connected_region_fill_top.f
rtl/bcrf_pkg.sv
rtl/bcrf_in_if.sv
rtl/bcrf_out_if.sv
rtl/bcrf_ctrl.sv
rtl/bcrf_dp.sv
rtl/border_connected_region_fill_top.sv
bench/border_connected_region_fill_top_test.sv
